// File: src/cim_pkg.sv
// shared types and constants of the block-cyclic index mapper
// no dependencies; imported by the interfaces, cim_cfg, the top level, the checker and the testbench
package cim_pkg;

	localparam int IDX_W_DEF      = 32;
	localparam int GRID_W_DEF     = 12;
	localparam int CFG_IDX_W      = 4;
	localparam int CFG_DATA_W_DEF = 32;

	// command and dimension codes of an input item
	localparam logic CMD_G2L = 1'b0;
	localparam logic CMD_L2G = 1'b1;
	localparam logic DIM_ROW = 1'b0;
	localparam logic DIM_COL = 1'b1;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_MISS   = 2'd1,
		STAT_BADCFG = 2'd2
	} cim_status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MATRIX_ORDER = 4'd0,
		REG_ROW_BLOCK    = 4'd1,
		REG_COL_BLOCK    = 4'd2,
		REG_GRID_ROWS    = 4'd3,
		REG_GRID_COLS    = 4'd4,
		REG_SOURCE_ROW   = 4'd5,
		REG_SOURCE_COL   = 4'd6,
		REG_MY_RANK      = 4'd7
	} cim_reg_t;

endpackage

// File: src/cim_if.sv
// valid/ready channel interfaces of the block-cyclic index mapper
// depends on cim_pkg for default widths
interface cim_item_if import cim_pkg::*; #(
	parameter int INDEX_WIDTH = IDX_W_DEF
);
	logic                   valid;
	logic                   ready;
	logic                   cmd;
	logic                   dim;
	logic [INDEX_WIDTH-1:0] index_in;

	modport source (output valid, cmd, dim, index_in, input ready);
	modport sink   (input valid, cmd, dim, index_in, output ready);
endinterface

interface cim_res_if import cim_pkg::*; #(
	parameter int INDEX_WIDTH = IDX_W_DEF
);
	logic                   valid;
	logic                   ready;
	logic [INDEX_WIDTH-1:0] mapped_index;
	logic [1:0]             status;
	logic [INDEX_WIDTH-1:0] local_extent;

	modport source (output valid, mapped_index, status, local_extent, input ready);
	modport sink   (input valid, mapped_index, status, local_extent, output ready);
endinterface

interface cim_cfg_if import cim_pkg::*; #(
	parameter int DATA_WIDTH = CFG_DATA_W_DEF
);
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [DATA_WIDTH-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// File: src/cim_pdiv.sv
// pipelined restoring divider, one quotient bit per stage, with side-band data
// no dependencies; used twice by the mapper top level
module cim_pdiv #(
	parameter int NUM_W  = 32,
	parameter int DEN_W  = 32,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] side,
	output logic              out_valid,
	output logic [NUM_W-1:0]  quo,
	output logic [DEN_W-1:0]  rem,
	output logic [SIDE_W-1:0] side_out
);

	// index 0 is the entry, index NUM_W the last register stage
	logic              v_s    [NUM_W+1];
	logic [DEN_W-1:0]  rem_s  [NUM_W+1];
	logic [NUM_W-1:0]  nq_s   [NUM_W+1];
	logic [DEN_W-1:0]  den_s  [NUM_W+1];
	logic [SIDE_W-1:0] side_s [NUM_W+1];

	assign v_s[0]    = in_valid;
	assign rem_s[0]  = '0;
	assign nq_s[0]   = num;
	assign den_s[0]  = den;
	assign side_s[0] = side;

	for (genvar j = 0; j < NUM_W; j++) begin : g_stage
		logic [DEN_W:0] trial;
		logic [DEN_W:0] diff;
		logic           ge;

		// dividend bits leave at the top, quotient bits enter at the bottom
		assign trial = {rem_s[j], nq_s[j][NUM_W-1]};
		assign diff  = trial - {1'b0, den_s[j]};
		assign ge    = trial >= {1'b0, den_s[j]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else if (en) begin
				v_s[j+1] <= v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				nq_s[j+1]   <= {nq_s[j][NUM_W-2:0], ge};
				den_s[j+1]  <= den_s[j];
				side_s[j+1] <= side_s[j];
			end
		end
	end

	assign out_valid = v_s[NUM_W];
	assign quo       = nq_s[NUM_W];
	assign rem       = rem_s[NUM_W];
	assign side_out  = side_s[NUM_W];

endmodule

// File: src/cim_cfg.sv
// configuration registers and the sequencer that derives grid coordinates and extents
// depends on cim_pkg and cim_cfg_if; shares one bit-serial divider between all its divisions
module cim_cfg import cim_pkg::*; #(
	parameter int INDEX_WIDTH = IDX_W_DEF,
	parameter int GRID_WIDTH  = GRID_W_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	cim_cfg_if.sink                cfg,
	output logic                   idle,
	output logic                   cfg_ok,
	output logic [INDEX_WIDTH-1:0] matrix_order,
	output logic [INDEX_WIDTH-1:0] row_block,
	output logic [INDEX_WIDTH-1:0] col_block,
	output logic [GRID_WIDTH:0]    grid_rows,
	output logic [GRID_WIDTH:0]    grid_cols,
	output logic [GRID_WIDTH-1:0]  first_row,
	output logic [GRID_WIDTH-1:0]  first_col,
	output logic [INDEX_WIDTH-1:0] extent_row,
	output logic [INDEX_WIDTH-1:0] extent_col
);

	localparam int IW  = INDEX_WIDTH;
	localparam int GW  = GRID_WIDTH;
	localparam int DVW = (IW > 2 * GW) ? IW : 2 * GW;
	localparam int CW  = $clog2(DVW);

	typedef enum logic [9:0] {
		S_IDLE     = 10'b0000000001,
		S_CHECK    = 10'b0000000010,
		S_RANK_DIV = 10'b0000000100,
		S_FIRST    = 10'b0000001000,
		S_NB_DIV   = 10'b0000010000,
		S_K_LOAD   = 10'b0000100000,
		S_K_DIV    = 10'b0001000000,
		S_MUL_K    = 10'b0010000000,
		S_MUL_NB   = 10'b0100000000,
		S_EXT      = 10'b1000000000
	} cim_seq_t;

	cim_seq_t         state_q;
	logic             dim_q;
	logic [IW-1:0]    mo_q, rb_q, cb_q;
	logic [GW:0]      gr_q, gc_q;
	logic [GW-1:0]    sr_q, sc_q;
	logic [2*GW-1:0]  rk_q;
	logic             ok_q;
	logic [GW-1:0]    first_r_q, first_c_q;
	logic [IW-1:0]    ext_r_q, ext_c_q;
	logic [IW-1:0]    nbm1_q, t1_q, t2_q;
	logic             modz_q;
	logic [DVW-1:0]   div_num_q, div_den_q, div_rem_q;
	logic [CW-1:0]    div_cnt_q;

	logic [DVW:0]     trial, diff;
	logic             ge, div_last;
	logic [DVW-1:0]   step_rem, step_num;
	logic [2*GW+1:0]  grid_size;
	logic             gr_fit, gc_fit, ok_nx;
	logic [GW+1:0]    sum_r, sum_c;
	logic [GW-1:0]    first_r_nx, first_c_nx;
	logic [GW-1:0]    cur_first;
	logic [IW-1:0]    cur_b, kq, ext_val;
	logic [GW:0]      cur_cnt;
	logic             cfg_wr;

	// shared serial divider step
	assign trial    = {div_rem_q, div_num_q[DVW-1]};
	assign diff     = trial - {1'b0, div_den_q};
	assign ge       = trial >= {1'b0, div_den_q};
	assign step_rem = ge ? diff[DVW-1:0] : trial[DVW-1:0];
	assign step_num = {div_num_q[DVW-2:0], ge};
	assign div_last = div_cnt_q == CW'(DVW - 1);

	// validity of the whole register set
	assign grid_size = (2*GW+2)'(gr_q) * (2*GW+2)'(gc_q);
	assign gr_fit    = !(gr_q[GW] && (gr_q[GW-1:0] != '0));
	assign gc_fit    = !(gc_q[GW] && (gc_q[GW-1:0] != '0));
	assign ok_nx     = (mo_q != '0) && (rb_q != '0) && (cb_q != '0)
		&& (gr_q != '0) && gr_fit && (gc_q != '0) && gc_fit
		&& ((GW+1)'(sr_q) < gr_q) && ((GW+1)'(sc_q) < gc_q)
		&& ((2*GW+2)'(rk_q) < grid_size);

	// first owned block offset, from rank / grid_cols left in the divider
	assign sum_r = (GW+2)'(GW'(div_num_q)) + (GW+2)'(gr_q) - (GW+2)'(sr_q);
	assign sum_c = (GW+2)'(GW'(div_rem_q)) + (GW+2)'(gc_q) - (GW+2)'(sc_q);
	assign first_r_nx = (sum_r >= (GW+2)'(gr_q)) ? GW'(sum_r - (GW+2)'(gr_q)) : GW'(sum_r);
	assign first_c_nx = (sum_c >= (GW+2)'(gc_q)) ? GW'(sum_c - (GW+2)'(gc_q)) : GW'(sum_c);

	assign cur_first = (dim_q == DIM_COL) ? first_c_q : first_r_q;
	assign cur_b     = (dim_q == DIM_COL) ? cb_q : rb_q;
	assign cur_cnt   = (dim_q == DIM_COL) ? gc_q : gr_q;
	assign kq        = IW'(div_num_q) + IW'(1);
	// last block is short: take off what it lacks of a full block
	assign ext_val   = modz_q ? (t1_q - cur_b + (mo_q - t2_q)) : t1_q;

	assign cfg_wr    = cfg.valid && cfg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			dim_q     <= DIM_ROW;
			div_cnt_q <= '0;
			mo_q      <= IW'(1);
			rb_q      <= IW'(1);
			cb_q      <= IW'(1);
			gr_q      <= (GW+1)'(1);
			gc_q      <= (GW+1)'(1);
			sr_q      <= '0;
			sc_q      <= '0;
			rk_q      <= '0;
			ok_q      <= 1'b1;
			first_r_q <= '0;
			first_c_q <= '0;
			ext_r_q   <= IW'(1);
			ext_c_q   <= IW'(1);
		end else if (cfg_wr) begin
			// a register write restarts the derivation
			state_q <= S_CHECK;
			unique case (cfg.index)
				REG_MATRIX_ORDER: mo_q <= cfg.data[IW-1:0];
				REG_ROW_BLOCK:    rb_q <= cfg.data[IW-1:0];
				REG_COL_BLOCK:    cb_q <= cfg.data[IW-1:0];
				REG_GRID_ROWS:    gr_q <= cfg.data[GW:0];
				REG_GRID_COLS:    gc_q <= cfg.data[GW:0];
				REG_SOURCE_ROW:   sr_q <= cfg.data[GW-1:0];
				REG_SOURCE_COL:   sc_q <= cfg.data[GW-1:0];
				REG_MY_RANK:      rk_q <= cfg.data[2*GW-1:0];
				default: begin
				end
			endcase
		end else begin
			unique case (state_q)
				S_IDLE: begin
				end
				S_CHECK: begin
					ok_q <= ok_nx;
					if (ok_nx) begin
						div_num_q <= DVW'(rk_q);
						div_den_q <= DVW'(gc_q);
						div_rem_q <= '0;
						div_cnt_q <= '0;
						state_q   <= S_RANK_DIV;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_RANK_DIV, S_NB_DIV, S_K_DIV: begin
					div_num_q <= step_num;
					div_rem_q <= step_rem;
					div_cnt_q <= div_cnt_q + CW'(1);
					if (div_last) begin
						state_q <= (state_q == S_RANK_DIV) ? S_FIRST :
							(state_q == S_NB_DIV) ? S_K_LOAD : S_MUL_K;
					end
				end
				S_FIRST: begin
					first_r_q <= first_r_nx;
					first_c_q <= first_c_nx;
					dim_q     <= DIM_ROW;
					div_num_q <= DVW'(mo_q - IW'(1));
					div_den_q <= DVW'(rb_q);
					div_rem_q <= '0;
					div_cnt_q <= '0;
					state_q   <= S_NB_DIV;
				end
				S_K_LOAD: begin
					nbm1_q <= IW'(div_num_q);
					if (DVW'(cur_first) > div_num_q) begin
						// this coordinate owns no block at all
						if (dim_q == DIM_ROW) begin
							ext_r_q   <= '0;
							dim_q     <= DIM_COL;
							div_num_q <= DVW'(mo_q - IW'(1));
							div_den_q <= DVW'(cb_q);
							div_rem_q <= '0;
							div_cnt_q <= '0;
							state_q   <= S_NB_DIV;
						end else begin
							ext_c_q <= '0;
							state_q <= S_IDLE;
						end
					end else begin
						div_num_q <= div_num_q - DVW'(cur_first);
						div_den_q <= DVW'(cur_cnt);
						div_rem_q <= '0;
						div_cnt_q <= '0;
						state_q   <= S_K_DIV;
					end
				end
				S_MUL_K: begin
					t1_q    <= kq * cur_b;
					modz_q  <= div_rem_q == '0;
					state_q <= S_MUL_NB;
				end
				S_MUL_NB: begin
					t2_q    <= nbm1_q * cur_b;
					state_q <= S_EXT;
				end
				S_EXT: begin
					if (dim_q == DIM_ROW) begin
						ext_r_q   <= ext_val;
						dim_q     <= DIM_COL;
						div_num_q <= DVW'(mo_q - IW'(1));
						div_den_q <= DVW'(cb_q);
						div_rem_q <= '0;
						div_cnt_q <= '0;
						state_q   <= S_NB_DIV;
					end else begin
						ext_c_q <= ext_val;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign cfg.ready    = 1'b1;
	assign idle         = state_q == S_IDLE;
	assign cfg_ok       = ok_q;
	assign matrix_order = mo_q;
	assign row_block    = rb_q;
	assign col_block    = cb_q;
	assign grid_rows    = gr_q;
	assign grid_cols    = gc_q;
	assign first_row    = first_r_q;
	assign first_col    = first_c_q;
	assign extent_row   = ext_r_q;
	assign extent_col   = ext_c_q;

endmodule

// File: src/block_cyclic_index_mapper_top.sv
// top level of the two-dimensional block-cyclic index mapper
// depends on cim_pkg, cim_if, cim_cfg and cim_pdiv
//
// Maps one matrix index per transfer between global and local numbering, in the row
// or column dimension, under a block-cyclic spread over a grid of processes. The block
// takes one item every clock cycle while the sequencer is idle and the skid buffer is
// empty. Each item passes through two pipelined dividers of one quotient bit per stage
// (index by block size, then block number by grid dimension), a product stage and an
// output register; with a one-entry skid buffer, items keep entering while a result
// waits to be taken. After every register write a sequencer checks the register set
// and, if it is valid, works out this rank's grid coordinates and the local extent
// of both dimensions with a shared bit-serial divider; until it is done no item is
// taken. Register writes are taken in every cycle and must come only while no item
// is in flight.
module block_cyclic_index_mapper_top import cim_pkg::*; #(
	parameter int INDEX_WIDTH = IDX_W_DEF,
	parameter int GRID_WIDTH  = GRID_W_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	cim_item_if.sink  item,
	cim_res_if.source result,
	cim_cfg_if.sink   cfg
);

	localparam int IW  = INDEX_WIDTH;
	localparam int GW  = GRID_WIDTH;
	localparam int SW2 = 3 + 2 * IW;

	typedef struct packed {
		logic [IW-1:0] mapped;
		cim_status_t   status;
		logic [IW-1:0] extent;
	} res_t;

	// derived configuration, to be kept stable by the user while items are in flight; the block does not enforce it
	logic          idle, cfg_ok;
	logic [IW-1:0] matrix_order, row_block, col_block, extent_row, extent_col;
	logic [GW:0]   grid_rows, grid_cols;
	logic [GW-1:0] first_row, first_col;

	cim_cfg #(
		.INDEX_WIDTH (INDEX_WIDTH),
		.GRID_WIDTH  (GRID_WIDTH)
	) u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.idle         (idle),
		.cfg_ok       (cfg_ok),
		.matrix_order (matrix_order),
		.row_block    (row_block),
		.col_block    (col_block),
		.grid_rows    (grid_rows),
		.grid_cols    (grid_cols),
		.first_row    (first_row),
		.first_col    (first_col),
		.extent_row   (extent_row),
		.extent_col   (extent_col)
	);

	// whole pipeline advances while the skid buffer is free
	logic en;
	logic skid_v_q, res_v_q;
	res_t skid_q, res_q;

	assign en         = !skid_v_q;
	assign item.ready = en && idle;

	// entry: range check against the order or the local extent
	logic [IW-1:0] ent_ext, ent_b;
	logic          ent_bad;

	assign ent_ext = (item.dim == DIM_COL) ? extent_col : extent_row;
	assign ent_b   = (item.dim == DIM_COL) ? col_block : row_block;
	assign ent_bad = (item.cmd == CMD_L2G) ? (item.index_in >= ent_ext)
		: (item.index_in >= matrix_order);

	// index / block size
	logic          v1;
	logic [IW-1:0] q1, r1;
	logic [2:0]    side1;

	cim_pdiv #(
		.NUM_W  (IW),
		.DEN_W  (IW),
		.SIDE_W (3)
	) u_div_blk (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (item.valid && item.ready),
		.num       (item.index_in),
		.den       (ent_b),
		.side      ({item.cmd, item.dim, ent_bad}),
		.out_valid (v1),
		.quo       (q1),
		.rem       (r1),
		.side_out  (side1)
	);

	// block number / grid dimension
	logic           v2;
	logic [IW-1:0]  q2;
	logic [GW:0]    rem2, d2_cnt;
	logic [SW2-1:0] side2;

	assign d2_cnt = (side1[1] == DIM_COL) ? grid_cols : grid_rows;

	cim_pdiv #(
		.NUM_W  (IW),
		.DEN_W  (GW + 1),
		.SIDE_W (SW2)
	) u_div_grid (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v1),
		.num       (q1),
		.den       (d2_cnt),
		.side      ({side1, q1, r1}),
		.out_valid (v2),
		.quo       (q2),
		.rem       (rem2),
		.side_out  (side2)
	);

	// product stage
	logic          cmd2, dim2, bad2;
	logic [IW-1:0] q1_2, r1_2, b2;
	logic [GW:0]   cnt2;
	logic [GW-1:0] first2;

	assign cmd2   = side2[2*IW+2];
	assign dim2   = side2[2*IW+1];
	assign bad2   = side2[2*IW];
	assign q1_2   = side2[2*IW-1:IW];
	assign r1_2   = side2[IW-1:0];
	assign b2     = (dim2 == DIM_COL) ? col_block : row_block;
	assign cnt2   = (dim2 == DIM_COL) ? grid_cols : grid_rows;
	assign first2 = (dim2 == DIM_COL) ? first_col : first_row;

	logic          v_s1, cmd_s1, dim_s1, miss_s1;
	logic [IW-1:0] prod_s1, r_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= v2;
		end
	end

	// owned exactly when the block number falls on this coordinate's residue
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= (cmd2 == CMD_G2L) ? (q2 * b2) : (q1_2 * IW'(cnt2) + IW'(first2));
			miss_s1 <= bad2 || ((cmd2 == CMD_G2L) && (rem2 != (GW+1)'(first2)));
			r_s1    <= r1_2;
			cmd_s1  <= cmd2;
			dim_s1  <= dim2;
		end
	end

	// final sum and status
	logic [IW-1:0] bo, mapped_nx;
	res_t          res_nx;

	assign bo        = (dim_s1 == DIM_COL) ? col_block : row_block;
	assign mapped_nx = (cmd_s1 == CMD_G2L) ? (prod_s1 + r_s1) : (prod_s1 * bo + r_s1);

	always_comb begin
		res_nx.status = !cfg_ok ? STAT_BADCFG : (miss_s1 ? STAT_MISS : STAT_OK);
		res_nx.mapped = (res_nx.status == STAT_OK) ? mapped_nx : '0;
		res_nx.extent = !cfg_ok ? '0 : ((dim_s1 == DIM_COL) ? extent_col : extent_row);
	end

	// output register and skid buffer
	logic push, load_res, res_from_skid, load_skid;

	assign push          = en && v_s1;
	assign load_res      = push && (!res_v_q || result.ready);
	assign res_from_skid = res_v_q && result.ready && skid_v_q;
	assign load_skid     = push && res_v_q && !result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (load_res || res_from_skid) begin
				res_v_q <= 1'b1;
			end else if (result.ready) begin
				res_v_q <= 1'b0;
			end
			if (load_skid) begin
				skid_v_q <= 1'b1;
			end else if (res_from_skid) begin
				skid_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_from_skid) begin
			res_q <= skid_q;
		end else if (load_res) begin
			res_q <= res_nx;
		end
		if (load_skid) begin
			skid_q <= res_nx;
		end
	end

	assign result.valid        = res_v_q;
	assign result.mapped_index = res_q.mapped;
	assign result.status       = res_q.status;
	assign result.local_extent = res_q.extent;

endmodule

// File: src/cim_checker.sv
// port-level checks on the result channel of the index mapper, bound to the top level
// depends on cim_pkg and block_cyclic_index_mapper_top
module cim_checker import cim_pkg::*; #(
	parameter int INDEX_WIDTH = IDX_W_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   res_valid,
	input logic                   res_ready,
	input logic [INDEX_WIDTH-1:0] res_mapped,
	input logic [1:0]             res_status,
	input logic [INDEX_WIDTH-1:0] res_extent
);

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_status == STAT_OK || res_status == STAT_MISS
			|| res_status == STAT_BADCFG))
		else $error("result status code out of range");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_status != STAT_OK) |-> (res_mapped == '0))
		else $error("mapped index not zero on a failed mapping");

	a_badcfg_extent: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_status == STAT_BADCFG) |-> (res_extent == '0))
		else $error("extent not zero under invalid configuration");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(res_mapped)
			&& $stable(res_status) && $stable(res_extent)))
		else $error("stalled result transfer changed");

endmodule

bind block_cyclic_index_mapper_top cim_checker #(
	.INDEX_WIDTH (INDEX_WIDTH)
) u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.res_mapped (result.mapped_index),
	.res_status (result.status),
	.res_extent (result.local_extent)
);

// File: dv/block_cyclic_index_mapper_top_tb.sv
// self-checking testbench of the block-cyclic index mapper top level
// depends on cim_pkg, cim_if and block_cyclic_index_mapper_top
`timescale 1ns / 1ps
module block_cyclic_index_mapper_top_tb;
	import cim_pkg::*;

	localparam int IW = 32;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES = 600;
	localparam int SETTLE_CYCLES = 200;

	typedef struct packed {
		logic          cmd;
		logic          dim;
		logic [IW-1:0] index_in;
	} map_req_t;

	typedef struct packed {
		logic [IW-1:0] mapped_index;
		logic [1:0]    status;
		logic [IW-1:0] local_extent;
	} map_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	cim_item_if #(.INDEX_WIDTH(IW)) item_ch ();
	cim_res_if  #(.INDEX_WIDTH(IW)) res_ch ();
	cim_cfg_if  #(.DATA_WIDTH(32))  cfg_ch ();

	block_cyclic_index_mapper_top #(.INDEX_WIDTH(IW), .GRID_WIDTH(12)) DUT (
		.clk(clk), .arst_n(arst_n), .item(item_ch), .result(res_ch), .cfg(cfg_ch)
	);

	always #4 clk = ~clk;

	// register copies seen by the mapping predictor
	longint unsigned order_q = 1, rblk_q = 1, cblk_q = 1, grows_q = 1, gcols_q = 1;
	longint unsigned srow_q = 0, scol_q = 0, rank_q = 0;

	map_req_t pending_reqs[$];
	map_res_t expected_maps[$];
	int  errors = 0;
	int  n_items = 0, n_results = 0, n_phases = 0;
	int  idle_cycles = 0;
	bit  item_took = 1'b0;
	int  hold_token = 0;

	// closed-form count of indices held locally in one dimension
	function automatic longint unsigned held_count(longint unsigned n, longint unsigned b,
			longint unsigned first, longint unsigned cnt);
		longint unsigned nb, k, total;
		nb = (n - 1) / b + 1;
		if (first >= nb) return 0;
		k = (nb - 1 - first) / cnt + 1;
		total = k * b;
		if ((nb - 1 - first) % cnt == 0) total -= b - (n - (nb - 1) * b);
		return total;
	endfunction

	function automatic map_res_t predict_map(map_req_t r);
		map_res_t o;
		longint unsigned b, src, cnt, coord, first, ext, idx, gb, mapped;
		o = '0;
		if (order_q == 0 || rblk_q == 0 || cblk_q == 0 || grows_q == 0 || grows_q > 4096 ||
				gcols_q == 0 || gcols_q > 4096 || srow_q >= grows_q || scol_q >= gcols_q ||
				rank_q >= grows_q * gcols_q) begin
			o.status = STAT_BADCFG;
			return o;
		end
		if (r.dim == DIM_ROW) begin
			b = rblk_q; src = srow_q; cnt = grows_q; coord = rank_q / gcols_q;
		end else begin
			b = cblk_q; src = scol_q; cnt = gcols_q; coord = rank_q % gcols_q;
		end
		idx = r.index_in;
		first = (coord + cnt - src) % cnt;
		ext = held_count(order_q, b, first, cnt);
		mapped = 0;
		o.status = STAT_OK;
		if (r.cmd == CMD_G2L) begin
			gb = idx / b;
			if (idx >= order_q || (src + gb) % cnt != coord) o.status = STAT_MISS;
			else mapped = ((gb - first) / cnt) * b + idx % b;
		end else begin
			if (idx >= ext) o.status = STAT_MISS;
			else mapped = ((idx / b) * cnt + first) * b + idx % b;
		end
		o.mapped_index = mapped[IW-1:0];
		o.local_extent = ext[IW-1:0];
		return o;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// input driver: a new item goes out once the previous transfer has happened
	int send_gap = 0;
	always @(negedge clk) begin
		map_req_t nxt;
		if (arst_n && (!item_ch.valid || item_took)) begin
			if (send_gap > 0 || pending_reqs.size() == 0) begin
				if (send_gap > 0) send_gap--;
				item_ch.valid <= 1'b0;
			end else begin
				nxt = pending_reqs.pop_front();
				item_ch.cmd      <= nxt.cmd;
				item_ch.dim      <= nxt.dim;
				item_ch.index_in <= nxt.index_in;
				item_ch.valid    <= 1'b1;
				send_gap = pick_gap();
			end
		end
	end

	// result back-pressure, with a long hold-off whenever one is requested
	int ready_gap = 0, hold_cnt = 0, hold_seen = 0;
	always @(negedge clk) begin
		if (hold_token != hold_seen) begin
			hold_seen = hold_token;
			hold_cnt = HOLD_CYCLES;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			res_ch.ready <= 1'b0;
		end else if (ready_gap > 0) begin
			ready_gap--;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= 1'b1;
			if ($urandom_range(0, 3) == 0) ready_gap = pick_gap();
		end
	end

	// monitor: predict on every item transfer, check every result transfer
	always @(posedge clk) begin
		map_res_t want, got;
		item_took = item_ch.valid && item_ch.ready;
		if (arst_n) begin
			if (item_took) begin
				expected_maps.push_back(predict_map({item_ch.cmd, item_ch.dim,
					item_ch.index_in}));
				n_items++;
			end
			if (res_ch.valid && res_ch.ready) begin
				got = {res_ch.mapped_index, res_ch.status, res_ch.local_extent};
				n_results++;
				if (expected_maps.size() == 0) begin
					$display("%0t: unexpected result %h", $time, got);
					errors++;
				end else begin
					want = expected_maps.pop_front();
					if (want.mapped_index !== got.mapped_index) begin
						$display("%0t: mapped_index expected %h actual %h", $time,
							want.mapped_index, got.mapped_index);
						errors++;
					end
					if (want.status !== got.status) begin
						$display("%0t: status expected %0d actual %0d", $time,
							want.status, got.status);
						errors++;
					end
					if (want.local_extent !== got.local_extent) begin
						$display("%0t: local_extent expected %h actual %h", $time,
							want.local_extent, got.local_extent);
						errors++;
					end
				end
			end
			// watchdog on cycles without any transfer
			if (item_took || (res_ch.valid && res_ch.ready) || (cfg_ch.valid && cfg_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog expired, %0d results outstanding", $time,
					expected_maps.size());
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	task automatic write_reg(cim_reg_t idx, logic [31:0] val);
		@(negedge clk);
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		cfg_ch.valid <= 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			REG_MATRIX_ORDER: order_q = val;
			REG_ROW_BLOCK:    rblk_q = val;
			REG_COL_BLOCK:    cblk_q = val;
			REG_GRID_ROWS:    grows_q = val & 32'h1FFF;
			REG_GRID_COLS:    gcols_q = val & 32'h1FFF;
			REG_SOURCE_ROW:   srow_q = val & 32'hFFF;
			REG_SOURCE_COL:   scol_q = val & 32'hFFF;
			REG_MY_RANK:      rank_q = val & 32'hFFFFFF;
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic set_all(logic [31:0] n, logic [31:0] rb, logic [31:0] cb, logic [31:0] gr,
			logic [31:0] gc, logic [31:0] sr, logic [31:0] sc, logic [31:0] rk);
		write_reg(REG_MATRIX_ORDER, n);
		write_reg(REG_ROW_BLOCK, rb);
		write_reg(REG_COL_BLOCK, cb);
		write_reg(REG_GRID_ROWS, gr);
		write_reg(REG_GRID_COLS, gc);
		write_reg(REG_SOURCE_ROW, sr);
		write_reg(REG_SOURCE_COL, sc);
		write_reg(REG_MY_RANK, rk);
		n_phases++;
	endtask

	// sender pause: everything sent and every result back
	task automatic drain();
		wait (pending_reqs.size() == 0 && !item_ch.valid && expected_maps.size() == 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic queue_req(logic c, logic d, logic [IW-1:0] i);
		pending_reqs.push_back({c, d, i});
	endtask

	// random items, mostly inside the interesting range of the current setting
	task automatic queue_random(int count);
		logic [IW-1:0] i;
		longint unsigned span;
		repeat (count) begin
			span = (order_q > 0) ? order_q + 4 : 8;
			case ($urandom_range(0, 9))
				0, 1:    i = $urandom;
				2:       i = order_q[IW-1:0] - $urandom_range(0, 2);
				default: i = (span > 64'hFFFF_FFFF) ? $urandom : $urandom_range(0, span - 1);
			endcase
			queue_req($urandom_range(0, 1), $urandom_range(0, 1), i);
		end
	endtask

	task automatic random_setting();
		int gr, gc;
		gr = $urandom_range(1, 8);
		gc = $urandom_range(1, 8);
		if ($urandom_range(0, 7) == 0)
			// occasionally a broken setting
			set_all($urandom_range(0, 50), $urandom_range(0, 4), $urandom_range(0, 4),
				$urandom_range(0, 9), $urandom_range(0, 9), $urandom_range(0, 9),
				$urandom_range(0, 9), $urandom_range(0, 90));
		else
			set_all($urandom_range(1, 200), $urandom_range(1, 20), $urandom_range(1, 20),
				gr, gc, $urandom_range(0, gr - 1), $urandom_range(0, gc - 1),
				$urandom_range(0, gr * gc - 1));
	endtask

	initial begin
		item_ch.valid = 1'b0;
		item_ch.cmd = CMD_G2L;
		item_ch.dim = DIM_ROW;
		item_ch.index_in = '0;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_MATRIX_ORDER;
		cfg_ch.data = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (SETTLE_CYCLES) @(negedge clk);

		// reset setting: a single index, single process
		queue_req(CMD_G2L, DIM_ROW, 0);
		queue_req(CMD_L2G, DIM_COL, 0);
		queue_req(CMD_G2L, DIM_COL, 1);
		queue_req(CMD_L2G, DIM_ROW, 32'hFFFF_FFFF);
		drain();

		// directed: small grid with offset source, all operations and misses
		set_all(10, 3, 2, 2, 3, 1, 2, 4);
		queue_req(CMD_G2L, DIM_ROW, 0);
		queue_req(CMD_G2L, DIM_ROW, 3);
		queue_req(CMD_G2L, DIM_ROW, 9);
		queue_req(CMD_G2L, DIM_ROW, 10);
		queue_req(CMD_G2L, DIM_COL, 2);
		queue_req(CMD_G2L, DIM_COL, 8);
		queue_req(CMD_G2L, DIM_COL, 32'hFFFF_FFFF);
		queue_req(CMD_L2G, DIM_ROW, 0);
		queue_req(CMD_L2G, DIM_ROW, 4);
		queue_req(CMD_L2G, DIM_COL, 1);
		queue_req(CMD_L2G, DIM_COL, 3);
		queue_req(CMD_L2G, DIM_COL, 32'h8000_0000);
		drain();

		// extremes: largest order and block, largest grid
		set_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 4096, 4096, 4095, 4095, 24'hFFFFFF);
		queue_req(CMD_G2L, DIM_ROW, 32'hFFFF_FFFE);
		queue_req(CMD_G2L, DIM_COL, 32'hFFFF_FFFF);
		queue_req(CMD_L2G, DIM_COL, 0);
		queue_req(CMD_L2G, DIM_ROW, 32'h5555_5555);
		queue_req(CMD_G2L, DIM_COL, 32'hAAAA_AAAA);
		drain();

		// invalid settings: grid above its limit, zero block, then a rank outside the grid
		set_all(100, 0, 5, 4097, 2, 0, 0, 0);
		queue_req(CMD_G2L, DIM_ROW, 1);
		queue_req(CMD_L2G, DIM_COL, 1);
		drain();
		set_all(100, 4, 5, 2, 2, 0, 0, 4);
		queue_req(CMD_G2L, DIM_COL, 1);
		drain();

		// random phases; the receiver stalls long once while enough items keep coming
		// to fill the whole pipeline
		for (int p = 0; p < 14; p++) begin
			random_setting();
			queue_random((p == 3) ? 120 : 24);
			if (p == 3) begin
				repeat (20) @(negedge clk);
				hold_token++;
			end
			drain();
		end

		repeat (100) @(negedge clk);
		$display("%0d items and %0d results checked over %0d register settings,", n_items,
			n_results, n_phases);
		$display("covering both mappings, both dimensions, misses and invalid settings");
		if (errors == 0 && expected_maps.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
